// ----- design/mcs_pkg.sv -----
`timescale 1ns / 1ps

package mcs_pkg;

  localparam int RandW   = 16;
  localparam int PeriodW = 24;
  localparam int KeyW    = 4;
  localparam int NotesW  = 4;
  localparam int NoteW   = 7;
  localparam int DegW    = 3;
  localparam int StepW   = 2;
  localparam int CfgIdxW = 2;

  localparam logic [NoteW-1:0] ROOT_PITCH = 7'd36;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] REG_CHORD_PERIOD    = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_SCALE_MODE      = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_KEY_OFFSET      = 2'd2;
  localparam logic [CfgIdxW-1:0] REG_NOTES_PER_CHORD = 2'd3;

  // program steps
  localparam logic [StepW-1:0] STEP_WAIT    = 2'd0;
  localparam logic [StepW-1:0] STEP_RELEASE = 2'd1;
  localparam logic [StepW-1:0] STEP_SEARCH  = 2'd2;
  localparam logic [StepW-1:0] STEP_PRESS   = 2'd3;

  // jump conditions
  typedef enum logic [1:0] {
    COND_CHANGE,
    COND_REL_DONE,
    COND_FOUND,
    COND_PRS_DONE
  } cond_t;

  // one control word per program step
  typedef struct packed {
    logic             take_in;
    logic             emit;
    logic             press;
    logic             advance;
    cond_t            cond;
    logic [StepW-1:0] target;
  } ctrl_t;

  function automatic ctrl_t ucode(logic [StepW-1:0] step);
    ctrl_t cw;
    cw = '{take_in: 1'b0, emit: 1'b0, press: 1'b0, advance: 1'b0,
           cond: COND_CHANGE, target: STEP_WAIT};
    case (step)
      STEP_WAIT: begin
        cw.take_in = 1'b1;
        cw.cond    = COND_CHANGE;
        cw.target  = STEP_RELEASE;
      end
      STEP_RELEASE: begin
        cw.emit    = 1'b1;
        cw.advance = 1'b1;
        cw.cond    = COND_REL_DONE;
        cw.target  = STEP_SEARCH;
      end
      STEP_SEARCH: begin
        cw.advance = 1'b1;
        cw.cond    = COND_FOUND;
        cw.target  = STEP_PRESS;
      end
      STEP_PRESS: begin
        cw.emit    = 1'b1;
        cw.press   = 1'b1;
        cw.advance = 1'b1;
        cw.cond    = COND_PRS_DONE;
        cw.target  = STEP_WAIT;
      end
      default: begin
        cw.target = STEP_WAIT;
      end
    endcase
    return cw;
  endfunction

  // cumulative transition probabilities in q0.16, row = current degree;
  // the last column always matches, so it is held at all ones
  localparam logic [RandW-1:0] CUM_TABLE [8][8] = '{
    '{16'd4369,  16'd13107, 16'd21845, 16'd34953, 16'd56798, 16'd61167,
      16'hFFFF, 16'hFFFF},
    '{16'd4369,  16'd8738,  16'd17476, 16'd21845, 16'd43691, 16'd56798,
      16'hFFFF, 16'hFFFF},
    '{16'd9362,  16'd14043, 16'd18725, 16'd28087, 16'd42130, 16'd51493,
      16'hFFFF, 16'hFFFF},
    '{16'd11916, 16'd17873, 16'd29789, 16'd35747, 16'd47663, 16'd59578,
      16'hFFFF, 16'hFFFF},
    '{16'd25486, 16'd29127, 16'd36409, 16'd43691, 16'd47332, 16'd54613,
      16'hFFFF, 16'hFFFF},
    '{16'd14043, 16'd23406, 16'd32768, 16'd42130, 16'd51493, 16'd56174,
      16'hFFFF, 16'hFFFF},
    '{16'd23406, 16'd32768, 16'd42130, 16'd46811, 16'd51493, 16'd60855,
      16'hFFFF, 16'hFFFF},
    '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
      16'hFFFF, 16'hFFFF}
  };

  localparam logic [3:0] MAJOR_STEPS [8] = '{4'd0, 4'd2, 4'd4, 4'd5, 4'd7, 4'd9, 4'd11, 4'd0};
  localparam logic [3:0] MINOR_STEPS [8] = '{4'd0, 4'd2, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd0};

endpackage

// ----- design/markov_chord_sequencer.sv -----
`timescale 1ns / 1ps

// a tick with no chord change is taken in the wait step and gives no event
// a chord change runs the release, search and press steps, one event a cycle
// in release and press while the output is taken, set by the microcode step loop
// throughput: one tick per cycle between changes, none taken while a change runs
// rst (synchronous) clears counters, degree, held count and restores register defaults
module markov_chord_sequencer #(
  parameter int MAX_NOTES = 8
) (
  input  logic                         clk,
  input  logic                         rst,
  // configuration write port
  input  logic                         cfg_we,
  input  logic [mcs_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [mcs_pkg::PeriodW-1:0]  cfg_data,
  // tdata: random_value[15:0]
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [15:0]                  s_axis_tdata,
  // tdata: note_number[6:0], zero pad [7]
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [7:0]                   m_axis_tdata,
  // tuser: is_press[0]
  output logic                         m_axis_tuser,
  output logic                         m_axis_tlast
);
  import mcs_pkg::*;

  localparam int CW = $clog2(MAX_NOTES + 1);
  localparam int IW = (CW > DegW) ? CW : DegW;
  localparam int AW = (MAX_NOTES > 1) ? $clog2(MAX_NOTES) : 1;

  // configuration registers
  logic [PeriodW-1:0] chord_period;
  logic               scale_mode;
  logic [KeyW-1:0]    key_offset;
  logic [NotesW-1:0]  notes_per_chord;

  // state
  logic [StepW-1:0]   step;
  logic [IW-1:0]      idx;
  logic [PeriodW-1:0] tick_count;
  logic [DegW-1:0]    chord_degree;
  logic [DegW-1:0]    scale_idx;
  logic [RandW-1:0]   rnd;
  logic [IW-1:0]      held_count;
  logic [NoteW-1:0]   held_notes [MAX_NOTES];

  // output register
  logic               out_valid;
  logic [NoteW-1:0]   out_note;
  logic               out_press;
  logic               out_last;

  ctrl_t              cw;
  logic               in_fire;
  logic               change;
  logic               out_free;
  logic               step_go;
  logic               found;
  logic               cond_hit;
  logic [IW-1:0]      cnt_sat;
  logic [IW-1:0]      idx_inc;
  logic [3:0]         scale_step;
  logic [NoteW-1:0]   press_note;
  logic [NoteW-1:0]   emit_note;
  logic               emit_last;
  logic [DegW:0]      scale_sum;
  logic [DegW-1:0]    scale_idx_next;

  assign cw            = ucode(step);
  assign s_axis_tready = cw.take_in && !rst;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign change        = tick_count >= chord_period;
  assign out_free      = !out_valid || m_axis_tready;
  assign step_go       = !cw.emit || out_free;
  assign idx_inc       = idx + 1'b1;

  // saturate notes per chord to the held note store
  always_comb begin
    if (int'(notes_per_chord) > MAX_NOTES) begin
      cnt_sat = IW'(MAX_NOTES);
    end else begin
      cnt_sat = IW'(notes_per_chord);
    end
  end

  // transition search compares one column a cycle
  assign found = CUM_TABLE[chord_degree][idx[DegW-1:0]] >= rnd;

  // jump condition of the current step
  always_comb begin
    case (cw.cond)
      COND_CHANGE:   cond_hit = in_fire && change;
      COND_REL_DONE: cond_hit = idx >= held_count;
      COND_FOUND:    cond_hit = found;
      COND_PRS_DONE: cond_hit = idx >= cnt_sat;
      default:       cond_hit = 1'b0;
    endcase
  end

  // note of a press and the event data
  assign scale_step = scale_mode ? MINOR_STEPS[scale_idx] : MAJOR_STEPS[scale_idx];
  assign press_note = ROOT_PITCH + {3'b000, key_offset} + {3'b000, scale_step};
  assign emit_note  = cw.press ? press_note : held_notes[idx[AW-1:0]];
  assign emit_last  = cw.press ? (idx_inc == cnt_sat)
                               : ((idx_inc == held_count) && (cnt_sat == '0));

  // stacked third: scale index advances by two, mod 7
  assign scale_sum      = {1'b0, scale_idx} + 4'd2;
  assign scale_idx_next = (scale_sum >= 4'd7) ? DegW'(scale_sum - 4'd7) : scale_sum[DegW-1:0];

  // sequencer, datapath and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      chord_period    <= 24'd88200;
      scale_mode      <= 1'b0;
      key_offset      <= '0;
      notes_per_chord <= 4'd3;
      step            <= STEP_WAIT;
      idx             <= '0;
      tick_count      <= '0;
      chord_degree    <= '0;
      held_count      <= '0;
      out_valid       <= 1'b0;
    end else begin
      // register writes
      if (cfg_we) begin
        case (cfg_index)
          REG_CHORD_PERIOD:    chord_period    <= cfg_data;
          REG_SCALE_MODE:      scale_mode      <= cfg_data[0];
          REG_KEY_OFFSET:      key_offset      <= cfg_data[KeyW-1:0];
          REG_NOTES_PER_CHORD: notes_per_chord <= cfg_data[NotesW-1:0];
          default: ;
        endcase
      end

      if (out_valid && m_axis_tready) begin
        out_valid <= 1'b0;
      end

      // tick request
      if (in_fire) begin
        rnd        <= s_axis_tdata;
        tick_count <= change ? PeriodW'(1) : tick_count + 1'b1;
      end

      if (cond_hit) begin
        step <= cw.target;
        idx  <= '0;
        if (cw.cond == COND_FOUND) begin
          chord_degree <= idx[DegW-1:0];
          scale_idx    <= idx[DegW-1:0];
        end
        if (cw.cond == COND_PRS_DONE) begin
          held_count <= cnt_sat;
        end
      end else if (cw.advance && step_go) begin
        idx <= idx_inc;
        if (cw.emit) begin
          out_valid <= 1'b1;
          out_press <= cw.press;
          out_note  <= emit_note;
          out_last  <= emit_last;
        end
        if (cw.press) begin
          held_notes[idx[AW-1:0]] <= press_note;
          scale_idx               <= scale_idx_next;
        end
      end
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {1'b0, out_note};
  assign m_axis_tuser  = out_press;
  assign m_axis_tlast  = out_last;

endmodule
